// ===== rtl/core/decimal_literal_recognizer_macros.svh =====
// assertion macros for the decimal literal recognizer
`ifndef DECIMAL_LITERAL_RECOGNIZER_MACROS_SVH
`define DECIMAL_LITERAL_RECOGNIZER_MACROS_SVH

`ifndef ASSERT_OFF
`define DLR_ASSERT_SAME(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
    else $error("dlr same-cycle check failed");
`define DLR_ASSERT_NEXT(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
    else $error("dlr next-cycle check failed");
`else
`define DLR_ASSERT_SAME(lbl, ck, rn, a, b)
`define DLR_ASSERT_NEXT(lbl, ck, rn, a, b)
`endif

`endif

// ===== rtl/core/dlr_pkg.sv =====
package dlr_pkg;

  typedef enum logic [9:0] {
    ST_LEAD  = 10'b00_0000_0001,
    ST_SIGN  = 10'b00_0000_0010,
    ST_INT   = 10'b00_0000_0100,
    ST_DOT   = 10'b00_0000_1000,
    ST_FRAC  = 10'b00_0001_0000,
    ST_EXP   = 10'b00_0010_0000,
    ST_ESIGN = 10'b00_0100_0000,
    ST_EDIG  = 10'b00_1000_0000,
    ST_TRAIL = 10'b01_0000_0000,
    ST_ERR   = 10'b10_0000_0000
  } scan_state_t;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_LOW_E = 8'd101;
  localparam logic [7:0] CH_UP_E  = 8'd69;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } dlr_item_t;

  typedef struct packed {
    logic      valid;
    dlr_item_t item;
  } dlr_stage_t;

  typedef struct packed {
    logic advance;
    logic at_start;
  } dlr_status_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_num(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_sign(input logic [7:0] b);
    return (b == CH_PLUS) || (b == CH_MINUS);
  endfunction

  function automatic logic is_exp(input logic [7:0] b);
    return (b == CH_LOW_E) || (b == CH_UP_E);
  endfunction

  function automatic scan_state_t next_state(input scan_state_t s, input logic [7:0] b);
    scan_state_t n;
    n = ST_ERR;
    case (s)
      ST_LEAD: begin
        if (is_space(b)) n = ST_LEAD;
        else if (is_sign(b)) n = ST_SIGN;
        else if (is_num(b)) n = ST_INT;
      end
      ST_SIGN: begin
        if (is_num(b)) n = ST_INT;
      end
      ST_INT: begin
        if (is_num(b)) n = ST_INT;
        else if (b == CH_DOT) n = ST_DOT;
        else if (is_exp(b)) n = ST_EXP;
        else if (is_space(b)) n = ST_TRAIL;
      end
      ST_DOT: begin
        if (is_num(b)) n = ST_FRAC;
      end
      ST_FRAC: begin
        if (is_num(b)) n = ST_FRAC;
        else if (is_exp(b)) n = ST_EXP;
        else if (is_space(b)) n = ST_TRAIL;
      end
      ST_EXP: begin
        if (is_sign(b)) n = ST_ESIGN;
        else if (is_num(b)) n = ST_EDIG;
      end
      ST_ESIGN: begin
        if (is_num(b)) n = ST_EDIG;
      end
      ST_EDIG: begin
        if (is_num(b)) n = ST_EDIG;
        else if (is_space(b)) n = ST_TRAIL;
      end
      ST_TRAIL: begin
        if (is_space(b)) n = ST_TRAIL;
      end
      default: begin
        n = ST_ERR;
      end
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/dlr_in_if.sv =====
interface dlr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== rtl/core/dlr_out_if.sv =====
interface dlr_out_if;
  logic valid;
  logic ready;
  logic is_valid;

  modport source (output valid, output is_valid, input ready);
  modport sink (input valid, input is_valid, output ready);
endinterface

// ===== rtl/core/dlr_in_stage.sv =====
module dlr_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  dlr_in_if.sink               in_ch,
  input  dlr_pkg::dlr_status_t status,
  output dlr_pkg::dlr_stage_t  stage
);
  import dlr_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  dlr_item_t item_r;
  logic      take;

  assign in_ch.ready = !valid_r || status.advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) valid_nxt = 1'b1;
    else if (status.advance) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.text_byte   <= in_ch.text_byte;
      item_r.end_of_text <= in_ch.end_of_text;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;
endmodule

// ===== rtl/core/dlr_scanner.sv =====
module dlr_scanner (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dlr_pkg::dlr_stage_t  stage,
  dlr_out_if.source            out_ch,
  output dlr_pkg::dlr_status_t status
);
  import dlr_pkg::*;

  scan_state_t state_r;
  scan_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        verdict_r;
  logic        advance;
  logic        closing;
  logic        accept_ok;

  assign advance = stage.valid &&
                   (!stage.item.end_of_text || !out_valid_r || out_ch.ready);
  assign closing = advance && stage.item.end_of_text;

  assign accept_ok = (state_r == ST_INT) || (state_r == ST_FRAC) ||
                     (state_r == ST_EDIG) || (state_r == ST_TRAIL);

  always_comb begin
    state_nxt = state_r;
    if (closing) state_nxt = ST_LEAD;
    else if (advance) state_nxt = next_state(state_r, stage.item.text_byte);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (closing) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LEAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // verdict register, loaded when the end transaction moves through
  always_ff @(posedge clk) begin
    if (closing) begin
      verdict_r <= accept_ok;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.is_valid = verdict_r;
  assign status.advance  = advance;
  assign status.at_start = (state_r == ST_LEAD);
endmodule

// ===== rtl/core/decimal_literal_recognizer.sv =====
// a byte transaction is registered in the input stage, then updates the scanner state register
// an end transaction is registered in the input stage, then loads the verdict register shown on the output
// one transaction per cycle when not stalled, set by the combinational state table lookup
// a held verdict stalls only a following end transaction, bytes keep flowing
// reset (rst_n low, synchronous): both stages empty, scanner in its start state
`include "decimal_literal_recognizer_macros.svh"

module decimal_literal_recognizer (
  input  logic      clk,
  input  logic      rst_n,
  dlr_in_if.sink    in_ch,
  dlr_out_if.source out_ch
);
  import dlr_pkg::*;

  dlr_stage_t  stage;
  dlr_status_t status;

  dlr_in_stage u_in_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .status (status),
    .stage  (stage)
  );

  dlr_scanner u_scanner (
    .clk    (clk),
    .rst_n  (rst_n),
    .stage  (stage),
    .out_ch (out_ch),
    .status (status)
  );

  `DLR_ASSERT_NEXT(a_end_restarts, clk, rst_n, stage.valid && stage.item.end_of_text && status.advance, status.at_start)
  `DLR_ASSERT_NEXT(a_end_gives_verdict, clk, rst_n, stage.valid && stage.item.end_of_text && status.advance, out_ch.valid)
  `DLR_ASSERT_SAME(a_no_overwrite, clk, rst_n, stage.valid && !status.advance, !in_ch.ready)
endmodule
